// ----- rtl/scc_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scc_pkg
// shared constants and types for the strongly connected components block
// ----------------------------------------------------------------------------
package scc_pkg;

	localparam int MAX_VERTICES_DEF = 64;
	localparam int MAX_EDGES_DEF    = 256;

	typedef enum logic [1:0] {
		FN_ADD = 2'd0,
		FN_RUN = 2'd1,
		FN_CLR = 2'd2,
		FN_NOP = 2'd3
	} scc_func_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_ADD,
		S_SCAN,
		S_DISC,
		S_DISC2,
		S_TOP,
		S_EDGE,
		S_CMP,
		S_POP,
		S_POP2,
		S_RET,
		S_RET2,
		S_FIN
	} scc_state_t;

endpackage

// ----- rtl/strongly_connected_components.sv -----
`timescale 1ns / 1ps
// run: time depends on the edges examined and the vertices visited, plus output stalls;
// every memory has a registered read port and a separate write port
// one request is worked on at a time; results leave through an output register
// reset (arst_n low): all edge lists empty, no edge dropped, vertex_count 1;
// the edge store is not cleared, no clearing pass
// ----------------------------------------------------------------------------
// strongly_connected_components
// edge list store and Tarjan depth-first search over memories, one result
// per vertex popped from the component stack
// ----------------------------------------------------------------------------
module strongly_connected_components #(
	parameter int MAX_VERTICES = scc_pkg::MAX_VERTICES_DEF,
	parameter int MAX_EDGES    = scc_pkg::MAX_EDGES_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_we,
	input  logic [6:0] cfg_wdata,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [1:0] func,
	input  logic [5:0] src_vertex,
	input  logic [5:0] dst_vertex,
	output logic       out_valid,
	input  logic       out_ready,
	output logic [5:0] vertex_id,
	output logic       component_end,
	output logic       last_result,
	output logic       edges_dropped
);

	localparam int VW = $clog2(MAX_VERTICES);
	localparam int EW = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
	localparam int CW = $clog2(MAX_EDGES + 1);
	localparam int FW = VW + 2 * EW + 1 + 7 + 7;

	scc_pkg::scc_state_t state_q, state_d;

	logic [6:0]              vc_q;
	logic [6:0]              n_eff;
	logic [MAX_VERTICES-1:0] list_valid_q, vis_q, onstk_q;
	logic [CW-1:0]           edge_cnt_q;
	logic                    ovf_q;
	logic [5:0]              req_src_q, req_dst_q;
	logic [6:0]              scan_q, csp_q, ssp_q, time_q;
	logic [VW-1:0]           dv_q, w_q;
	logic                    adv_q;
	logic [VW-1:0]           top_v_q;
	logic [EW-1:0]           top_e_q, top_tail_q;
	logic                    top_more_q;
	logic [6:0]              top_low_q, top_disc_q;
	logic                    pend_v_q, pend_end_q;
	logic [VW-1:0]           pend_id_q;
	logic                    out_valid_q, out_end_q, out_last_q, out_ovf_q;
	logic [5:0]              out_id_q;

	// memories
	logic [5:0]      tgt_mem  [MAX_EDGES];
	logic [EW-1:0]   nxt_mem  [MAX_EDGES];
	logic [2*EW-1:0] list_mem [MAX_VERTICES];
	logic [6:0]      disc_mem [MAX_VERTICES];
	logic [VW-1:0]   scc_mem  [MAX_VERTICES];
	logic [FW-1:0]   call_mem [MAX_VERTICES];

	logic [5:0]      tgt_rd_q;
	logic [EW-1:0]   nxt_rd_q;
	logic [2*EW-1:0] list_rd_q;
	logic [6:0]      disc_rd_q;
	logic [VW-1:0]   scc_rd_q;
	logic [FW-1:0]   call_rd_q;

	logic            tgt_we, nxt_we, list_we, disc_we, scc_we, call_we;
	logic [EW-1:0]   edge_ra, tgt_wa, nxt_wa, nxt_wd;
	logic [VW-1:0]   list_ra, list_wa, disc_ra, disc_wa, scc_ra, scc_wa, call_ra, call_wa;
	logic [2*EW-1:0] list_wd;
	logic [FW-1:0]   call_wd;

	logic            in_fire, out_free, add_drop, load_out, load_last;
	logic [EW-1:0]   cnt_idx, list_head_rd, list_tail_rd;
	logic [VW-1:0]   edge_w, scc_w;
	logic            edge_out_range;
	logic [VW-1:0]   rd_v;
	logic [EW-1:0]   rd_e, rd_tail;
	logic            rd_more;
	logic [6:0]      rd_low, rd_disc;
	logic [6:0]      csp_m1, csp_m2, ssp_m1;

	assign n_eff = (vc_q > 7'(MAX_VERTICES)) ? 7'(MAX_VERTICES) : vc_q;
	assign in_fire  = in_valid && in_ready;
	assign out_free = !out_valid_q || out_ready;
	assign add_drop = ({1'b0, src_vertex} >= n_eff) || ({1'b0, dst_vertex} >= n_eff)
		|| (edge_cnt_q >= CW'(MAX_EDGES));
	assign cnt_idx        = edge_cnt_q[EW-1:0];
	assign list_head_rd   = list_rd_q[2*EW-1:EW];
	assign list_tail_rd   = list_rd_q[EW-1:0];
	assign edge_w         = tgt_rd_q[VW-1:0];
	assign edge_out_range = ({1'b0, tgt_rd_q} >= n_eff);
	assign scc_w          = scc_rd_q;
	assign {rd_v, rd_e, rd_tail, rd_more, rd_low, rd_disc} = call_rd_q;
	assign csp_m1 = 7'(csp_q - 7'd1);
	assign csp_m2 = 7'(csp_q - 7'd2);
	assign ssp_m1 = 7'(ssp_q - 7'd1);

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			scc_pkg::S_IDLE: begin
				if (in_fire) begin
					case (func)
						scc_pkg::FN_ADD: state_d = add_drop ? scc_pkg::S_IDLE : scc_pkg::S_ADD;
						scc_pkg::FN_RUN: state_d = scc_pkg::S_SCAN;
						default:         state_d = scc_pkg::S_IDLE;
					endcase
				end
			end
			scc_pkg::S_ADD:   state_d = scc_pkg::S_IDLE;
			scc_pkg::S_SCAN: begin
				if (scan_q == n_eff)
					state_d = scc_pkg::S_FIN;
				else if (!vis_q[scan_q[VW-1:0]])
					state_d = scc_pkg::S_DISC;
			end
			scc_pkg::S_DISC:  state_d = scc_pkg::S_DISC2;
			scc_pkg::S_DISC2: state_d = scc_pkg::S_TOP;
			scc_pkg::S_TOP: begin
				if (top_more_q)
					state_d = scc_pkg::S_EDGE;
				else if (top_low_q == top_disc_q)
					state_d = scc_pkg::S_POP;
				else
					state_d = scc_pkg::S_RET;
			end
			scc_pkg::S_EDGE: begin
				if (edge_out_range)
					state_d = scc_pkg::S_TOP;
				else if (!vis_q[edge_w])
					state_d = scc_pkg::S_DISC;
				else
					state_d = scc_pkg::S_CMP;
			end
			scc_pkg::S_CMP:   state_d = scc_pkg::S_TOP;
			scc_pkg::S_POP:   state_d = scc_pkg::S_POP2;
			scc_pkg::S_POP2: begin
				if (!pend_v_q || out_free)
					state_d = (scc_w == top_v_q) ? scc_pkg::S_RET : scc_pkg::S_POP;
			end
			scc_pkg::S_RET:   state_d = (csp_q > 7'd1) ? scc_pkg::S_RET2 : scc_pkg::S_SCAN;
			scc_pkg::S_RET2:  state_d = scc_pkg::S_TOP;
			scc_pkg::S_FIN: begin
				if (!pend_v_q || out_free)
					state_d = scc_pkg::S_IDLE;
			end
			default:          state_d = scc_pkg::S_IDLE;
		endcase
	end

	// memory controls and handshake outputs
	always_comb begin
		in_ready  = (state_q == scc_pkg::S_IDLE);
		tgt_we    = 1'b0;
		tgt_wa    = cnt_idx;
		nxt_we    = 1'b0;
		nxt_wa    = list_tail_rd;
		nxt_wd    = cnt_idx;
		list_we   = 1'b0;
		list_wa   = req_src_q[VW-1:0];
		list_wd   = {cnt_idx, cnt_idx};
		list_ra   = dv_q;
		edge_ra   = top_e_q;
		disc_we   = 1'b0;
		disc_wa   = dv_q;
		disc_ra   = edge_w;
		scc_we    = 1'b0;
		scc_wa    = ssp_q[VW-1:0];
		scc_ra    = ssp_q[VW-1:0];
		call_we   = 1'b0;
		call_wa   = csp_m1[VW-1:0];
		call_wd   = {top_v_q, top_e_q, top_tail_q, top_more_q, top_low_q, top_disc_q};
		call_ra   = csp_m2[VW-1:0];
		load_out  = 1'b0;
		load_last = 1'b0;
		case (state_q)
			scc_pkg::S_IDLE: list_ra = src_vertex[VW-1:0];
			scc_pkg::S_ADD: begin
				tgt_we  = 1'b1;
				list_we = 1'b1;
				if (list_valid_q[req_src_q[VW-1:0]]) begin
					nxt_we  = 1'b1;
					list_wd = {list_head_rd, cnt_idx};
				end
			end
			scc_pkg::S_DISC: begin
				disc_we = 1'b1;
				scc_we  = 1'b1;
				call_we = (csp_q != 7'd0);
			end
			scc_pkg::S_POP:  scc_ra = ssp_m1[VW-1:0];
			scc_pkg::S_POP2: load_out = pend_v_q && out_free;
			scc_pkg::S_FIN: begin
				load_out  = pend_v_q && out_free;
				load_last = 1'b1;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (tgt_we)
			tgt_mem[tgt_wa] <= req_dst_q;
		if (nxt_we)
			nxt_mem[nxt_wa] <= nxt_wd;
		tgt_rd_q <= tgt_mem[edge_ra];
		nxt_rd_q <= nxt_mem[edge_ra];
	end

	always_ff @(posedge clk) begin
		if (list_we)
			list_mem[list_wa] <= list_wd;
		list_rd_q <= list_mem[list_ra];
	end

	always_ff @(posedge clk) begin
		if (disc_we)
			disc_mem[disc_wa] <= 7'(time_q + 7'd1);
		disc_rd_q <= disc_mem[disc_ra];
	end

	always_ff @(posedge clk) begin
		if (scc_we)
			scc_mem[scc_wa] <= dv_q;
		scc_rd_q <= scc_mem[scc_ra];
	end

	always_ff @(posedge clk) begin
		if (call_we)
			call_mem[call_wa] <= call_wd;
		call_rd_q <= call_mem[call_ra];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vc_q <= 7'd1;
		end else if (cfg_we) begin
			vc_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= scc_pkg::S_IDLE;
			list_valid_q <= '0;
			vis_q        <= '0;
			onstk_q      <= '0;
			edge_cnt_q   <= '0;
			ovf_q        <= 1'b0;
			scan_q       <= '0;
			csp_q        <= '0;
			ssp_q        <= '0;
			time_q       <= '0;
			pend_v_q     <= 1'b0;
		end else begin
			state_q <= state_d;
			case (state_q)
				scc_pkg::S_IDLE: begin
					if (in_fire) begin
						case (func)
							scc_pkg::FN_ADD: begin
								if (add_drop)
									ovf_q <= 1'b1;
							end
							scc_pkg::FN_RUN: begin
								scan_q   <= '0;
								csp_q    <= '0;
								ssp_q    <= '0;
								time_q   <= '0;
								vis_q    <= '0;
								onstk_q  <= '0;
								pend_v_q <= 1'b0;
							end
							scc_pkg::FN_CLR: begin
								list_valid_q <= '0;
								edge_cnt_q   <= '0;
								ovf_q        <= 1'b0;
							end
							default: ;
						endcase
					end
				end
				scc_pkg::S_ADD: begin
					list_valid_q[req_src_q[VW-1:0]] <= 1'b1;
					edge_cnt_q <= CW'(edge_cnt_q + 1'b1);
				end
				scc_pkg::S_SCAN: begin
					if (scan_q != n_eff && vis_q[scan_q[VW-1:0]])
						scan_q <= 7'(scan_q + 7'd1);
				end
				scc_pkg::S_DISC: begin
					time_q        <= 7'(time_q + 7'd1);
					vis_q[dv_q]   <= 1'b1;
					onstk_q[dv_q] <= 1'b1;
					ssp_q         <= 7'(ssp_q + 7'd1);
					csp_q         <= 7'(csp_q + 7'd1);
				end
				scc_pkg::S_POP:  ssp_q <= ssp_m1;
				scc_pkg::S_POP2: begin
					if (!pend_v_q || out_free) begin
						onstk_q[scc_w] <= 1'b0;
						pend_v_q       <= 1'b1;
					end
				end
				scc_pkg::S_RET:  csp_q <= csp_m1;
				scc_pkg::S_FIN: begin
					if (out_free)
						pend_v_q <= 1'b0;
				end
				default: ;
			endcase
		end
	end

	// payload registers of the search
	always_ff @(posedge clk) begin
		case (state_q)
			scc_pkg::S_IDLE: begin
				req_src_q <= src_vertex;
				req_dst_q <= dst_vertex;
			end
			scc_pkg::S_SCAN: dv_q <= scan_q[VW-1:0];
			scc_pkg::S_DISC2: begin
				top_v_q    <= dv_q;
				top_e_q    <= list_head_rd;
				top_tail_q <= list_tail_rd;
				top_more_q <= list_valid_q[dv_q];
				top_low_q  <= time_q;
				top_disc_q <= time_q;
			end
			scc_pkg::S_TOP: begin
				if (top_more_q) begin
					// last edge of the list ends the walk, else follow next
					if (top_e_q == top_tail_q) begin
						top_more_q <= 1'b0;
						adv_q      <= 1'b0;
					end else begin
						adv_q <= 1'b1;
					end
				end
			end
			scc_pkg::S_EDGE: begin
				if (adv_q)
					top_e_q <= nxt_rd_q;
				dv_q <= edge_w;
				w_q  <= edge_w;
			end
			scc_pkg::S_CMP: begin
				if (onstk_q[w_q] && disc_rd_q < top_low_q)
					top_low_q <= disc_rd_q;
			end
			scc_pkg::S_POP2: begin
				if (!pend_v_q || out_free) begin
					pend_id_q  <= scc_w;
					pend_end_q <= (scc_w == top_v_q);
				end
			end
			scc_pkg::S_RET2: begin
				// parent frame comes back, child low link folds into it
				top_v_q    <= rd_v;
				top_e_q    <= rd_e;
				top_tail_q <= rd_tail;
				top_more_q <= rd_more;
				top_low_q  <= (top_low_q < rd_low) ? top_low_q : rd_low;
				top_disc_q <= rd_disc;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load_out) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			out_id_q   <= 6'(pend_id_q);
			out_end_q  <= pend_end_q;
			out_last_q <= load_last;
			out_ovf_q  <= ovf_q;
		end
	end

	assign out_valid     = out_valid_q;
	assign vertex_id     = out_id_q;
	assign component_end = out_end_q;
	assign last_result   = out_last_q;
	assign edges_dropped = out_ovf_q;

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		load_out |-> out_free)
		else $error("result register overwritten before taken");

	a_pop_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == scc_pkg::S_POP) |-> (ssp_q != 7'd0))
		else $error("component stack popped while empty");

	a_idle_stack_empty: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == scc_pkg::S_IDLE) |-> (csp_q == 7'd0))
		else $error("call stack not empty after run");

	a_stack_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(csp_q <= 7'(MAX_VERTICES)) && (ssp_q <= 7'(MAX_VERTICES)))
		else $error("stack depth beyond vertex count");

endmodule
